@@ rtl/lapf_pkg.sv @@
// shared types and constants for the 3x3 laplacian edge filter
package lapf_pkg;

   // configuration register indexes
   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // field widths fixed by the stream format
   localparam int PIXEL_W  = 8;
   localparam int ROW_W    = 12;
   localparam int COLUMN_W = 10;
   localparam int FWIDTH_W = 11;
   localparam int CSR_W    = 12;

   // reset values of the configuration registers
   localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [ROW_W-1:0]    FRAME_HEIGHT_RESET = 12'd480;

   // saturation limit of the edge response
   localparam logic [PIXEL_W-1:0] EDGE_MAX = 8'd255;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               start_of_frame;
   } req_payload_type;

   typedef struct packed {
      logic [ROW_W-1:0]    row;
      logic [COLUMN_W-1:0] column;
      logic [PIXEL_W-1:0]  edge_value;
   } rsp_payload_type;

   // the five taps of the four-neighbour kernel
   typedef struct packed {
      logic [PIXEL_W-1:0] up;
      logic [PIXEL_W-1:0] left;
      logic [PIXEL_W-1:0] centre;
      logic [PIXEL_W-1:0] right;
      logic [PIXEL_W-1:0] down;
   } window_type;

endpackage

@@ rtl/lapf_ram.sv @@
// generic single write port ram with registered read
module lapf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lapf_kernel.sv @@
// four-neighbour laplacian with absolute value and saturation
module lapf_kernel (
   input  lapf_pkg::window_type               window,
   output logic [lapf_pkg::PIXEL_W-1:0]       edge_value
);

   logic [9:0]  pos_sum;
   logic [9:0]  neg_sum;
   logic [10:0] diff;
   logic [9:0]  mag;

   // up + down + left + right - 4 * centre
   always_comb begin
      pos_sum = 10'(window.up) + 10'(window.down) + 10'(window.left) + 10'(window.right);
      neg_sum = {window.centre, 2'b00};
      diff    = {1'b0, pos_sum} - {1'b0, neg_sum};
      mag     = diff[10] ? 10'(-diff) : diff[9:0];
      edge_value = (mag > 10'(lapf_pkg::EDGE_MAX)) ? lapf_pkg::EDGE_MAX : mag[7:0];
   end

endmodule

@@ rtl/laplacian_edge_filter_3x3_unit.sv @@
// top level of the 3x3 four-neighbour laplacian edge filter
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_ready  lapf_pkg::req_payload_type
//   rsp_         out         rsp_valid/rsp_ready  lapf_pkg::rsp_payload_type
//   csr_         in          csr_wr_en            csr_index, csr_wr_data
//
// one pixel per clock while rsp_ready holds; a transferred pixel is registered in stage one
// (position logic and line store read), then passes the kernel into the output register
// line stores are one ram with a registered read; a same-address write/read pair is
// forwarded around it when the frame is one pixel wide
// synchronous reset clears counters, window and valids; line store contents stay unknown
// a stalled output holds the pipeline stage behind it; req_ready drops only then
module laplacian_edge_filter_3x3_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lapf_pkg::req_payload_type          req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lapf_pkg::rsp_payload_type          rsp_data,
   input  logic                               csr_wr_en,
   input  lapf_pkg::csr_index_type            csr_index,
   input  logic [lapf_pkg::CSR_W-1:0]         csr_wr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = ((CW + 1) > lapf_pkg::FWIDTH_W) ? (CW + 1) : lapf_pkg::FWIDTH_W;
   localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);
   localparam int PW = lapf_pkg::PIXEL_W;
   localparam int RW = lapf_pkg::ROW_W;

   // configuration
   logic [lapf_pkg::FWIDTH_W-1:0] frame_width_ff;
   logic [RW-1:0]                 frame_height_ff;

   // position counters
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // stage one
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_emit_ff;
   logic [CW-1:0]               s1_addr_ff;
   logic [PW-1:0]               s1_pixel_ff;
   logic [RW-1:0]               s1_row_ff;
   logic [lapf_pkg::COLUMN_W-1:0] s1_col_ff;
   logic                        s1_fwd_ff;
   logic [PW-1:0]               s1_fwd_up_ff;
   logic [PW-1:0]               s1_fwd_mid_ff;

   // window: entries 0..2 are column c-1 (upper, middle, lower), 3..5 column c-2
   logic [PW-1:0] win_ff [6];

   // output register
   logic                      rsp_valid_ff;
   lapf_pkg::rsp_payload_type rsp_data_ff;

   logic [WW-1:0]   eff_w;
   logic [WW-1:0]   col_ext;
   logic [CW-1:0]   col_base;
   logic [RW-1:0]   row_base;
   logic [CW-1:0]   c_cur;
   logic [WW-1:0]   c_ext;
   logic [WW-1:0]   c_next;
   logic            wrap;
   logic            emit;
   logic [WW-1:0]   col_m1;
   logic            adv;
   logic            s1_move;
   logic            req_fire;
   logic            fwd_hit;
   logic [2*PW-1:0] ram_rd_data;
   logic [PW-1:0]   up_c;
   logic [PW-1:0]   mid_c;
   logic [PW-1:0]   edge_value;
   lapf_pkg::window_type window;

   // handshake and pipeline advance
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && adv;
   assign req_ready = !s1_valid_ff || adv;
   assign req_fire  = req_valid && req_ready;

   // effective width clamped to 1..MAX_WIDTH
   always_comb begin
      eff_w = WW'(frame_width_ff);
      if (eff_w == '0) begin
         eff_w = WW'(1);
      end else if (eff_w > MAX_W) begin
         eff_w = MAX_W;
      end
   end

   // position of the incoming pixel and next counter values
   always_comb begin
      col_base = req_data.start_of_frame ? '0 : col_ff;
      row_base = req_data.start_of_frame ? '0 : row_ff;
      col_ext  = {{(WW-CW){1'b0}}, col_base};
      c_cur    = (col_ext >= eff_w) ? '0 : col_base;
      c_ext    = {{(WW-CW){1'b0}}, c_cur};
      c_next   = c_ext + WW'(1);
      wrap     = c_next >= eff_w;
      col_in   = wrap ? '0 : c_next[CW-1:0];
      row_in   = (wrap && row_base != '1) ? row_base + RW'(1) : row_base;
      col_m1   = c_ext - WW'(1);
      emit     = (row_base >= RW'(2)) && (c_ext >= WW'(2)) &&
                 (row_base < frame_height_ff) &&
                 ((row_base - RW'(1)) >= (frame_height_ff >> 1));
   end

   // read of the line store collides with the write of the item ahead
   assign fwd_hit = s1_move && (s1_addr_ff == c_cur);

   // stage one valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // line store: upper row in the high byte, middle row in the low byte
   lapf_ram #(
      .WIDTH (2 * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_addr_ff),
      .wr_data ({mid_c, s1_pixel_ff}),
      .rd_en   (req_fire),
      .rd_addr (c_cur),
      .rd_data (ram_rd_data)
   );

   // column c of the two stored rows
   assign up_c  = s1_fwd_ff ? s1_fwd_up_ff  : ram_rd_data[2*PW-1:PW];
   assign mid_c = s1_fwd_ff ? s1_fwd_mid_ff : ram_rd_data[PW-1:0];

   // kernel taps around center (r-1, c-1)
   always_comb begin
      window.up     = win_ff[0];
      window.centre = win_ff[1];
      window.down   = win_ff[2];
      window.left   = win_ff[4];
      window.right  = mid_c;
   end

   lapf_kernel u_kernel (
      .window     (window),
      .edge_value (edge_value)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lapf_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= lapf_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lapf_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_wr_data[lapf_pkg::FWIDTH_W-1:0];
            end
            lapf_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wr_data[RW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_fire) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (adv) begin
            rsp_valid_ff <= s1_valid_ff && s1_emit_ff;
         end
      end
   end

   // window shift on each item leaving stage one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_move) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= up_c;
         win_ff[1] <= mid_c;
         win_ff[2] <= s1_pixel_ff;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_emit_ff    <= emit;
         s1_addr_ff    <= c_cur;
         s1_pixel_ff   <= req_data.pixel;
         s1_row_ff     <= row_base - RW'(1);
         s1_col_ff     <= col_m1[lapf_pkg::COLUMN_W-1:0];
         s1_fwd_ff     <= fwd_hit;
         s1_fwd_up_ff  <= mid_c;
         s1_fwd_mid_ff <= s1_pixel_ff;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff.row        <= s1_row_ff;
         rsp_data_ff.column     <= s1_col_ff;
         rsp_data_ff.edge_value <= edge_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
